// ----- hdl/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// Depends on nothing; used by tcw_cell_mem, tcw_ctrl and text_console_writer.
package tcw_pkg;

	localparam int ROWS_DEFAULT = 25;
	localparam int COLS_DEFAULT = 80;

	localparam int OP_W       = 3;
	localparam int CHAR_W     = 8;
	localparam int COLOR_W    = 4;
	localparam int POS_W      = 8;
	localparam int OUT_ROW_W  = 5;
	localparam int OUT_COL_W  = 7;

	localparam logic [7:0] BLANK        = 8'h20;
	localparam logic [7:0] ATTR_DEFAULT = 8'h02;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;

	typedef enum logic [OP_W-1:0] {
		OP_PUTCHAR     = 3'd0,
		OP_WRITE_CELL  = 3'd1,
		OP_MOVE_CURSOR = 3'd2,
		OP_SET_COLOR   = 3'd3,
		OP_CLEAR       = 3'd4,
		OP_READ_CELL   = 3'd5
	} op_t;

	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] attr;
	} cell_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	typedef struct packed {
		logic init_busy;
		logic sweep_busy;
	} stat_t;

endpackage

// ----- hdl/tcw_cell_mem.sv -----
// Cell store: one write port, one read port, registered read data.
// Depends on tcw_pkg for the cell and control types.
module tcw_cell_mem #(
	parameter int DEPTH = tcw_pkg::ROWS_DEFAULT * tcw_pkg::COLS_DEFAULT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  tcw_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]     wr_addr,
	input  tcw_pkg::cell_t    wr_data,
	input  logic [AW-1:0]     rd_addr,
	output tcw_pkg::cell_t    rd_data
);

	tcw_pkg::cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/tcw_ctrl.sv -----
// Console sequencer: decodes words, drives the cell store, sweeps for
// reset, clear and scroll, and holds the result register.
// Depends on tcw_pkg.
module tcw_ctrl #(
	parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
	parameter int COLS = tcw_pkg::COLS_DEFAULT,
	parameter int CELLS = ROWS * COLS,
	parameter int AW = $clog2(CELLS)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic [tcw_pkg::OP_W-1:0]         op,
	input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
	input  logic [tcw_pkg::COLOR_W-1:0]      fore,
	input  logic [tcw_pkg::COLOR_W-1:0]      back,
	input  logic [tcw_pkg::POS_W-1:0]        row_in,
	input  logic [tcw_pkg::POS_W-1:0]        col_in,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [tcw_pkg::OUT_ROW_W-1:0]    cursor_row,
	output logic [tcw_pkg::OUT_COL_W-1:0]    cursor_col,
	output logic [tcw_pkg::CHAR_W-1:0]       cell_char,
	output logic [tcw_pkg::CHAR_W-1:0]       cell_attr,
	output tcw_pkg::mem_ctl_t                mem_ctl,
	output logic [AW-1:0]                    wr_addr,
	output tcw_pkg::cell_t                   wr_data,
	output logic [AW-1:0]                    rd_addr,
	input  tcw_pkg::cell_t                   rd_data,
	output tcw_pkg::stat_t                   stat
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_SRC  = AW'(CELLS - COLS - 1);
	localparam logic [AW-1:0] BOTTOM    = AW'(CELLS - COLS);
	localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
	localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_SCROLL,
		ST_DRAIN,
		ST_FILL,
		ST_DONE
	} state_t;

	state_t state_q;
	logic init_q;
	logic [AW-1:0] cnt_q;
	logic [7:0] fill_attr_q;
	logic [7:0] cur_attr_q;
	logic [RW-1:0] cur_row_q;
	logic [CW-1:0] cur_col_q;

	logic [tcw_pkg::OP_W-1:0] op_q;
	logic [7:0] ch_q;
	logic [7:0] attr_in_q;
	logic [tcw_pkg::POS_W-1:0] row_q;
	logic [tcw_pkg::POS_W-1:0] col_q;

	logic copy_vld_s1;
	logic [AW-1:0] copy_addr_s1;

	logic [7:0] rd_char_q;
	logic [7:0] rd_attr_q;
	logic res_vld_q;
	logic [tcw_pkg::OUT_ROW_W-1:0] res_row_q;
	logic [tcw_pkg::OUT_COL_W-1:0] res_col_q;
	logic [7:0] res_char_q;
	logic [7:0] res_attr_q;

	logic in_range;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] tgt_addr;
	logic [AW-1:0] src_addr;
	logic [RW-1:0] nx_row;
	logic [CW-1:0] nx_col;
	logic [7:0] nx_attr;
	logic go_scroll;
	logic go_fill;
	logic go_read;

	assign in_range = (row_q < tcw_pkg::POS_W'(ROWS)) && (col_q < tcw_pkg::POS_W'(COLS));
	assign cur_addr = AW'(cur_row_q) * AW'(COLS) + AW'(cur_col_q);
	assign tgt_addr = AW'(row_q) * AW'(COLS) + AW'(col_q);
	assign src_addr = cnt_q + AW'(COLS);

	always_comb begin
		mem_ctl   = '0;
		wr_addr   = cur_addr;
		wr_data   = '{ch: ch_q, attr: cur_attr_q};
		rd_addr   = tgt_addr;
		nx_row    = cur_row_q;
		nx_col    = cur_col_q;
		nx_attr   = cur_attr_q;
		go_scroll = 1'b0;
		go_fill   = 1'b0;
		go_read   = 1'b0;
		case (state_q)
			ST_EXEC: begin
				case (tcw_pkg::op_t'(op_q))
					tcw_pkg::OP_PUTCHAR: begin
						if (ch_q == tcw_pkg::CH_NEWLINE) begin
							nx_col = '0;
							if (cur_row_q == LAST_ROW) begin
								go_scroll = 1'b1;
							end else begin
								nx_row = cur_row_q + RW'(1);
							end
						end else if (ch_q == tcw_pkg::CH_RETURN) begin
							nx_col = '0;
						end else if (ch_q == tcw_pkg::CH_BACKSPACE) begin
							if (cur_col_q != '0) begin
								nx_col = cur_col_q - CW'(1);
								mem_ctl.wr_en = 1'b1;
								wr_addr = cur_addr - AW'(1);
								wr_data = '{ch: tcw_pkg::BLANK, attr: tcw_pkg::ATTR_DEFAULT};
							end
						end else begin
							mem_ctl.wr_en = 1'b1;
							if (cur_col_q == LAST_COL) begin
								nx_col = '0;
								if (cur_row_q == LAST_ROW) begin
									go_scroll = 1'b1;
								end else begin
									nx_row = cur_row_q + RW'(1);
								end
							end else begin
								nx_col = cur_col_q + CW'(1);
							end
						end
					end
					tcw_pkg::OP_WRITE_CELL: begin
						mem_ctl.wr_en = in_range;
						wr_addr = tgt_addr;
						wr_data = '{ch: ch_q, attr: attr_in_q};
					end
					tcw_pkg::OP_MOVE_CURSOR: begin
						nx_row = (row_q >= tcw_pkg::POS_W'(ROWS)) ? LAST_ROW : RW'(row_q);
						nx_col = (col_q >= tcw_pkg::POS_W'(COLS)) ? LAST_COL : CW'(col_q);
					end
					tcw_pkg::OP_SET_COLOR: begin
						nx_attr = attr_in_q;
					end
					tcw_pkg::OP_CLEAR: begin
						nx_attr = attr_in_q;
						nx_row  = '0;
						nx_col  = '0;
						go_fill = 1'b1;
					end
					tcw_pkg::OP_READ_CELL: begin
						mem_ctl.rd_en = in_range;
						go_read = in_range;
					end
					default: begin
					end
				endcase
			end
			ST_SCROLL: begin
				mem_ctl.rd_en = 1'b1;
				rd_addr = src_addr;
				mem_ctl.wr_en = copy_vld_s1;
				wr_addr = copy_addr_s1;
				wr_data = rd_data;
			end
			ST_DRAIN: begin
				mem_ctl.wr_en = copy_vld_s1;
				wr_addr = copy_addr_s1;
				wr_data = rd_data;
			end
			ST_FILL: begin
				mem_ctl.wr_en = 1'b1;
				wr_addr = cnt_q;
				wr_data = '{ch: tcw_pkg::BLANK, attr: fill_attr_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			init_q      <= 1'b1;
			cnt_q       <= '0;
			fill_attr_q <= tcw_pkg::ATTR_DEFAULT;
			cur_attr_q  <= tcw_pkg::ATTR_DEFAULT;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			copy_vld_s1 <= 1'b0;
			rd_char_q   <= '0;
			rd_attr_q   <= '0;
			res_vld_q   <= 1'b0;
		end else begin
			copy_vld_s1 <= (state_q == ST_SCROLL);
			if (res_vld_q && result_ready && state_q != ST_DONE) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					cur_row_q  <= nx_row;
					cur_col_q  <= nx_col;
					cur_attr_q <= nx_attr;
					rd_char_q  <= '0;
					rd_attr_q  <= '0;
					if (go_scroll) begin
						cnt_q   <= '0;
						state_q <= ST_SCROLL;
					end else if (go_fill) begin
						cnt_q       <= '0;
						fill_attr_q <= attr_in_q;
						state_q     <= ST_FILL;
					end else if (go_read) begin
						state_q <= ST_RDWAIT;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_RDWAIT: begin
					rd_char_q <= rd_data.ch;
					rd_attr_q <= rd_data.attr;
					state_q   <= ST_DONE;
				end
				ST_SCROLL: begin
					if (cnt_q == LAST_SRC) begin
						cnt_q   <= BOTTOM;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					fill_attr_q <= cur_attr_q;
					state_q     <= ST_FILL;
				end
				ST_FILL: begin
					if (cnt_q == LAST_CELL) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_DONE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_DONE: begin
					if (!res_vld_q || result_ready) begin
						res_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= cnt_q;
		if (state_q == ST_IDLE && item_valid) begin
			op_q      <= op;
			ch_q      <= char_code;
			attr_in_q <= {back, fore};
			row_q     <= row_in;
			col_q     <= col_in;
		end
		if (state_q == ST_DONE && (!res_vld_q || result_ready)) begin
			res_row_q  <= tcw_pkg::OUT_ROW_W'(cur_row_q);
			res_col_q  <= tcw_pkg::OUT_COL_W'(cur_col_q);
			res_char_q <= rd_char_q;
			res_attr_q <= rd_attr_q;
		end
	end

	assign item_ready      = (state_q == ST_IDLE);
	assign result_valid    = res_vld_q;
	assign cursor_row      = res_row_q;
	assign cursor_col      = res_col_q;
	assign cell_char       = res_char_q;
	assign cell_attr       = res_attr_q;
	assign stat.init_busy  = init_q;
	assign stat.sweep_busy = (state_q == ST_SCROLL) || (state_q == ST_DRAIN)
		|| (state_q == ST_FILL);

endmodule

// ----- hdl/text_console_writer.sv -----
// Text console writer: ROWS x COLS cell store with cursor and color.
// One word at a time: item_ready stays low from acceptance until the
// result is registered, and through the store sweeps of clear and scroll.
// Reset: cursor 0,0, color 0x02; a pass over all ROWS*COLS cells then
// blanks the store while item_ready stays low.
module text_console_writer #(
	parameter int ROWS = tcw_pkg::ROWS_DEFAULT,
	parameter int COLS = tcw_pkg::COLS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [tcw_pkg::OP_W-1:0]      op,
	input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcw_pkg::COLOR_W-1:0]   fore,
	input  logic [tcw_pkg::COLOR_W-1:0]   back,
	input  logic [tcw_pkg::POS_W-1:0]     row_in,
	input  logic [tcw_pkg::POS_W-1:0]     col_in,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [tcw_pkg::OUT_ROW_W-1:0] cursor_row,
	output logic [tcw_pkg::OUT_COL_W-1:0] cursor_col,
	output logic [tcw_pkg::CHAR_W-1:0]    cell_char,
	output logic [tcw_pkg::CHAR_W-1:0]    cell_attr
);

	localparam int CELLS = ROWS * COLS;
	localparam int AW = $clog2(CELLS);

	tcw_pkg::mem_ctl_t mem_ctl;
	tcw_pkg::stat_t stat;
	tcw_pkg::cell_t wr_data;
	tcw_pkg::cell_t rd_data;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	tcw_ctrl #(
		.ROWS(ROWS),
		.COLS(COLS),
		.CELLS(CELLS),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.op(op),
		.char_code(char_code),
		.fore(fore),
		.back(back),
		.row_in(row_in),
		.col_in(col_in),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.cell_char(cell_char),
		.cell_attr(cell_attr),
		.mem_ctl(mem_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.stat(stat)
	);

	tcw_cell_mem #(
		.DEPTH(CELLS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.ctl(mem_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

`ifndef SYNTHESIS
	a_init_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		stat.init_busy |-> !item_ready)
		else $error("word accepted during reset sweep");

	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		stat.sweep_busy |-> !item_ready)
		else $error("word accepted during store sweep");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second word taken while one is in flight");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (int'(cursor_row) < ROWS) && (int'(cursor_col) < COLS))
		else $error("cursor out of range");
`endif

endmodule
